/* hw/rtl/imusfd_pkg.sv */
// Shared types and constants of the inertial sensor serial frame decoder.
package imusfd_pkg;

  // Widths of the result fields.
  localparam int unsigned AXIS_W = 25;
  localparam int unsigned TEMP_W = 17;
  localparam int unsigned RAW_W  = 16;

  // Frame kinds as reported on the output.
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // One completed frame as captured by the sync stage.
  typedef struct packed {
    logic [1:0]              kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic signed [RAW_W-1:0] raw_t;
    logic [7:0]              sum;
  } frame_t;

  // One scaled result.
  typedef struct packed {
    logic [1:0]               kind;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [TEMP_W-1:0] temp_q8;
    logic [7:0]               sum;
  } result_t;

endpackage

/* hw/rtl/imusfd_sync.sv */
// Header hunt, type check and payload capture for the eleven-byte frame.
module imusfd_sync (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_vld_i,
  input  logic [7:0]          byte_i,
  output logic                frame_vld_o,
  output imusfd_pkg::frame_t  frame_o
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_TYPE    = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_FIRST = 8'h51;
  localparam logic [7:0] TYPE_LAST  = 8'h53;
  localparam logic [3:0] POS_SUM    = 4'd8;

  logic [1:0] phase_q, phase_d;
  logic [3:0] pos_q, pos_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] payload_q [8];
  logic       pay_we;
  logic       type_ok;
  logic [7:0] kind_wide;

  assign type_ok   = (byte_i >= TYPE_FIRST) && (byte_i <= TYPE_LAST);
  assign kind_wide = byte_i - TYPE_FIRST;

  // Next-state logic, advanced once per accepted beat.
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    kind_d      = kind_q;
    pay_we      = 1'b0;
    frame_vld_o = 1'b0;
    if (byte_vld_i) begin
      case (phase_q)
        PH_TYPE: begin
          if (type_ok) begin
            kind_d  = kind_wide[1:0];
            pos_d   = '0;
            phase_d = PH_COLLECT;
          end else if (byte_i != HDR_BYTE) begin
            phase_d = PH_HUNT;
          end
        end
        PH_COLLECT: begin
          if (pos_q < POS_SUM) begin
            pay_we = 1'b1;
            pos_d  = pos_q + 4'd1;
          end else begin
            frame_vld_o = 1'b1;
            phase_d     = PH_HUNT;
            pos_d       = '0;
          end
        end
        default: begin
          // Hunting; the unused phase code behaves the same way.
          phase_d = (byte_i == HDR_BYTE) ? PH_TYPE : PH_HUNT;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      kind_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      kind_q  <= kind_d;
    end
  end

  // Payload bytes; all eight are written before the sum byte reads them.
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      payload_q[pos_q[2:0]] <= byte_i;
    end
  end

  // Little-endian words of the frame, with the sum byte taken as it arrives.
  always_comb begin
    frame_o.kind  = kind_q;
    frame_o.raw_x = {payload_q[1], payload_q[0]};
    frame_o.raw_y = {payload_q[3], payload_q[2]};
    frame_o.raw_z = {payload_q[5], payload_q[4]};
    frame_o.raw_t = {payload_q[7], payload_q[6]};
    frame_o.sum   = byte_i;
  end

  // A frame is only issued on the sum byte of a collected frame.
  a_frame_on_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_vld_o |-> (phase_q == PH_COLLECT) && (pos_q == POS_SUM))
    else $error("frame issued outside the sum byte");

  // The byte position never runs past the sum byte.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_SUM)
    else $error("byte position out of range");

  // A valid type byte always starts collection at position zero.
  a_type_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_vld_i && (phase_q == PH_TYPE) && type_ok)
      |=> (phase_q == PH_COLLECT) && (pos_q == 4'd0))
    else $error("type byte did not start collection");

endmodule

/* hw/rtl/imusfd_scale.sv */
// Axis gain and temperature scaling, with one product register stage.
module imusfd_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 frame_vld_i,
  input  imusfd_pkg::frame_t   frame_i,
  output logic                 vld_o,
  output imusfd_pkg::result_t  res_o
);

  localparam int unsigned PROD_W     = 38;
  localparam logic [22:0] TEMP_RECIP = 23'd6316129;   // ceil(2^29 / 85)
  localparam int unsigned RECIP_SH   = 23;            // 29 less the factor 64
  localparam logic signed [imusfd_pkg::TEMP_W-1:0] TEMP_OFFSET = 17'sd9280;

  // Raw word times the gain of the frame kind, built from shifts and adds.
  function automatic logic signed [imusfd_pkg::AXIS_W-1:0] axis_gain(
    input logic signed [imusfd_pkg::RAW_W-1:0] raw,
    input logic [1:0]                          kind
  );
    logic signed [imusfd_pkg::AXIS_W-1:0] r;
    logic signed [imusfd_pkg::AXIS_W-1:0] p;
    r = {{(imusfd_pkg::AXIS_W-imusfd_pkg::RAW_W){raw[imusfd_pkg::RAW_W-1]}}, raw};
    case (kind)
      imusfd_pkg::KIND_ACCEL: p = r <<< 2;
      imusfd_pkg::KIND_GYRO:  p = (r <<< 9) - (r <<< 4) + (r <<< 2);
      imusfd_pkg::KIND_ANGLE: p = (r <<< 5) + (r <<< 3) + (r <<< 2) + r;
      default:                p = '0;
    endcase
    return p;
  endfunction

  logic                                 vld_q;
  logic [1:0]                           kind_q;
  logic signed [imusfd_pkg::AXIS_W-1:0] ax_q, ay_q, az_q;
  logic                                 tneg_q;
  logic [PROD_W-1:0]                    tprod_q;
  logic [7:0]                           sum_q;

  logic [imusfd_pkg::RAW_W-1:0]         t_mag;
  logic [PROD_W-1:0]                    tprod_d;
  logic [imusfd_pkg::TEMP_W-1:0]        t_quot;

  // Magnitude of the temperature word; the most negative word gives 32768.
  assign t_mag   = frame_i.raw_t[imusfd_pkg::RAW_W-1] ?
                   (~frame_i.raw_t + 16'd1) : frame_i.raw_t;
  assign tprod_d = {{(PROD_W-imusfd_pkg::RAW_W){1'b0}}, t_mag} *
                   {{(PROD_W-23){1'b0}}, TEMP_RECIP};

  // Product stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= frame_vld_i;
    end
  end

  // Product stage payload.
  always_ff @(posedge clk_i) begin
    if (adv_i && frame_vld_i) begin
      kind_q  <= frame_i.kind;
      ax_q    <= axis_gain(frame_i.raw_x, frame_i.kind);
      ay_q    <= axis_gain(frame_i.raw_y, frame_i.kind);
      az_q    <= axis_gain(frame_i.raw_z, frame_i.kind);
      tneg_q  <= frame_i.raw_t[imusfd_pkg::RAW_W-1];
      tprod_q <= tprod_d;
      sum_q   <= frame_i.sum;
    end
  end

  // Quotient of |raw|*256/340, then sign and offset; truncation is toward zero.
  assign t_quot = {2'b00, tprod_q[RECIP_SH+14:RECIP_SH]};

  always_comb begin
    res_o.kind    = kind_q;
    res_o.axis_x  = ax_q;
    res_o.axis_y  = ay_q;
    res_o.axis_z  = az_q;
    res_o.temp_q8 = tneg_q ? (TEMP_OFFSET - $signed(t_quot))
                           : (TEMP_OFFSET + $signed(t_quot));
    res_o.sum     = sum_q;
  end

  assign vld_o = vld_q;

endmodule

/* hw/rtl/imu_serial_frame_decoder_core.sv */
// Top level of the inertial sensor serial frame decoder.
//
//   channel  dir  beat content                                   width
//   s_axis   in   tdata: rx_byte                                 8
//   m_axis   out  tuser: frame_kind; tdata: axes, temp, sum      2 / 104
//
// One received byte is taken per cycle. A frame result passes from its sum byte
// through the product register of the scaler and then the output register.
// Bytes that complete no frame leave no result.
// Reset clears the sync state and the valid bits; payload registers are not
// reset. While the output register holds an untaken result and the product
// stage is also full, s_axis_tready_o is low; otherwise bytes keep flowing.
module imu_serial_frame_decoder_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] rx_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,   // [24:0] axis_x, [49:25] axis_y,
                                         // [74:50] axis_z, [91:75] temperature_q8,
                                         // [99:92] received_sum, [103:100] zero
  output logic [1:0]   m_axis_tuser_o    // [1:0] frame_kind
);

  logic                byte_vld;
  logic                frame_vld;
  imusfd_pkg::frame_t  frame;
  logic                p_vld;
  imusfd_pkg::result_t p_res;
  logic                out_adv;
  logic                p_adv;

  logic                m_vld_q;
  imusfd_pkg::result_t m_res_q;

  // Stage advance: each stage moves when the next one is empty or draining.
  assign out_adv         = !m_vld_q || m_axis_tready_i;
  assign p_adv           = !p_vld || out_adv;
  assign s_axis_tready_o = p_adv;
  assign byte_vld        = s_axis_tvalid_i && s_axis_tready_o;

  imusfd_sync u_sync (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (byte_vld),
    .byte_i     (s_axis_tdata_i),
    .frame_vld_o(frame_vld),
    .frame_o    (frame)
  );

  imusfd_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (p_adv),
    .frame_vld_i(frame_vld),
    .frame_i    (frame),
    .vld_o      (p_vld),
    .res_o      (p_res)
  );

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (out_adv) begin
      m_vld_q <= p_vld;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_adv && p_vld) begin
      m_res_q <= p_res;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tuser_o  = m_res_q.kind;
  assign m_axis_tdata_o  = {4'b0000, m_res_q.sum, m_res_q.temp_q8,
                            m_res_q.axis_z, m_res_q.axis_y, m_res_q.axis_x};

  // With both stages full and the output stalled, no byte may be taken.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vld_q && !m_axis_tready_i && p_vld) |-> !s_axis_tready_o)
    else $error("byte accepted while the result path is full");

  // A frame issued on the sum byte shows up in the product stage next cycle.
  a_frame_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_vld |=> p_vld)
    else $error("frame lost on its way into the product stage");

  // A result in the product stage is moved into a free output register.
  a_result_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_vld && out_adv) |=> m_vld_q)
    else $error("result lost on its way to the output register");

endmodule

/* tb/sv/imu_serial_frame_decoder_core_tb.sv */
// Self-checking testbench of the inertial sensor serial frame decoder core.
`timescale 1ns / 100ps

module imu_serial_frame_decoder_core_tb;

  // Bytes that steer the frame sync.
  localparam logic [7:0] HDR_BYTE        = 8'h55;
  localparam logic [7:0] TYPE_ACCEL_BYTE = 8'h51;
  localparam logic [7:0] TYPE_GYRO_BYTE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE_BYTE = 8'h53;

  // Axis gains in units of 2^-13 and the temperature offset in 1/256 degC.
  localparam int GAIN_ACCEL  = 4;
  localparam int GAIN_GYRO   = 500;
  localparam int GAIN_ANGLE  = 45;
  localparam int TEMP_OFFSET = 9280;
  localparam int TEMP_DIV    = 340;

  localparam int PAYLOAD_BYTES = 8;
  localparam int RANDOM_BYTES  = 580;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_TYPE,
    PH_COLLECT
  } sync_phase_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  // Shared run state.
  bit          quiet = 1'b0;
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned kind_seen [3] = '{0, 0, 0};

  // Predictor state of the frame sync.
  sync_phase_e          trk_phase = PH_HUNT;
  logic [3:0]           trk_pos = '0;
  logic [1:0]           trk_kind = '0;
  logic [63:0]          trk_payload = '0;
  imusfd_pkg::result_t  pending_frames[$];

  imu_serial_frame_decoder_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scale one raw axis word by the gain of its frame kind.
  function automatic logic [imusfd_pkg::AXIS_W-1:0] scale_axis(
    input logic signed [15:0] raw,
    input logic [1:0]         kind
  );
    int gain;
    int prod;
    case (kind)
      imusfd_pkg::KIND_ACCEL: gain = GAIN_ACCEL;
      imusfd_pkg::KIND_GYRO:  gain = GAIN_GYRO;
      imusfd_pkg::KIND_ANGLE: gain = GAIN_ANGLE;
      default:                gain = 0;
    endcase
    prod = int'(raw) * gain;
    return prod[imusfd_pkg::AXIS_W-1:0];
  endfunction

  // Temperature in 1/256 degC; the division truncates toward zero.
  function automatic logic [imusfd_pkg::TEMP_W-1:0] scale_temp(
    input logic signed [15:0] raw
  );
    int q;
    q = TEMP_OFFSET + (int'(raw) * 256) / TEMP_DIV;
    return q[imusfd_pkg::TEMP_W-1:0];
  endfunction

  // Advance the predicted sync state by one accepted byte.
  task automatic track_byte(input logic [7:0] b);
    imusfd_pkg::result_t exp_frame;
    case (trk_phase)
      PH_TYPE: begin
        if (b == TYPE_ACCEL_BYTE || b == TYPE_GYRO_BYTE || b == TYPE_ANGLE_BYTE) begin
          trk_kind  = 2'(b - TYPE_ACCEL_BYTE);
          trk_pos   = '0;
          trk_phase = PH_COLLECT;
        end else if (b != HDR_BYTE) begin
          trk_phase = PH_HUNT;
        end
      end
      PH_COLLECT: begin
        if (trk_pos < PAYLOAD_BYTES) begin
          trk_payload[8*trk_pos +: 8] = b;
          trk_pos = trk_pos + 4'd1;
        end else begin
          exp_frame.kind    = trk_kind;
          exp_frame.axis_x  = scale_axis(trk_payload[15:0], trk_kind);
          exp_frame.axis_y  = scale_axis(trk_payload[31:16], trk_kind);
          exp_frame.axis_z  = scale_axis(trk_payload[47:32], trk_kind);
          exp_frame.temp_q8 = scale_temp(trk_payload[63:48]);
          exp_frame.sum     = b;
          pending_frames.push_back(exp_frame);
          trk_phase = PH_HUNT;
          trk_pos   = '0;
        end
      end
      default: begin
        trk_phase = (b == HDR_BYTE) ? PH_TYPE : PH_HUNT;
      end
    endcase
  endtask

  // Send one byte on the input stream and wait for its beat.
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 30) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    track_byte(b);
    bytes_sent++;
  endtask

  // Send a complete well-formed frame.
  task automatic send_frame(input logic [1:0] kind, input logic [15:0] raw_x,
                            input logic [15:0] raw_y, input logic [15:0] raw_z,
                            input logic [15:0] raw_t, input logic [7:0] sum);
    send_byte(HDR_BYTE);
    send_byte(TYPE_ACCEL_BYTE + 8'(kind));
    send_byte(raw_x[7:0]);
    send_byte(raw_x[15:8]);
    send_byte(raw_y[7:0]);
    send_byte(raw_y[15:8]);
    send_byte(raw_z[7:0]);
    send_byte(raw_z[15:8]);
    send_byte(raw_t[7:0]);
    send_byte(raw_t[15:8]);
    send_byte(sum);
  endtask

  // Drop valid and wait until every predicted frame has come out.
  task automatic wait_frames_out();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  // Raw word with a bias toward the extremes.
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Each frame kind once, with the largest and smallest raw values.
  task automatic test_frame_kinds();
    send_frame(imusfd_pkg::KIND_ACCEL, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 8'hFF);
    send_frame(imusfd_pkg::KIND_GYRO,  16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 8'h00);
    send_frame(imusfd_pkg::KIND_ANGLE, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 8'hA5);
  endtask

  // Sync recovery: a repeated header, a bad type and header bytes in the payload.
  task automatic test_sync_recovery();
    send_byte(8'h00);
    send_byte(HDR_BYTE);
    send_byte(8'h50);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_frame(imusfd_pkg::KIND_GYRO, 16'h5555, 16'h5555, 16'h5551, 16'hFE9C, HDR_BYTE);
  endtask

  // The sender holds off until the decoder has delivered everything.
  task automatic test_drain_pause();
    send_frame(2'($urandom_range(2)), pick_raw(), pick_raw(), pick_raw(), pick_raw(),
               8'($urandom));
    wait_frames_out();
    send_frame(imusfd_pkg::KIND_ANGLE, pick_raw(), pick_raw(), pick_raw(), pick_raw(),
               8'($urandom));
  endtask

  // Mostly well-formed frames with random content, mixed with noise and broken headers.
  task automatic test_random_stream();
    int unsigned start_bytes;
    int unsigned pick;
    int unsigned n;
    start_bytes = bytes_sent;
    quiet = 1'b1;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      if (bytes_sent - start_bytes > 120) quiet = 1'b0;
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_frame(2'($urandom_range(2)), pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                   8'($urandom));
      end else if (pick < 85) begin
        n = $urandom_range(6, 1);
        repeat (n) send_byte(8'($urandom));
      end else if (pick < 95) begin
        send_byte(HDR_BYTE);
        if ($urandom_range(1)) send_byte(HDR_BYTE);
        send_byte(8'($urandom));
      end else begin
        send_byte(HDR_BYTE);
        send_byte(8'h54);
        send_frame(2'($urandom_range(2)), pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                   8'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver stalls at random except during a quiet stretch.
  always @(posedge clk_i) begin
    m_axis_tready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
  end

  // Compare each output beat with the oldest predicted frame.
  always @(posedge clk_i) begin
    imusfd_pkg::result_t got;
    imusfd_pkg::result_t exp_frame;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind    = m_axis_tuser_o;
      got.axis_x  = m_axis_tdata_o[24:0];
      got.axis_y  = m_axis_tdata_o[49:25];
      got.axis_z  = m_axis_tdata_o[74:50];
      got.temp_q8 = m_axis_tdata_o[91:75];
      got.sum     = m_axis_tdata_o[99:92];
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame kind %0d sum %h", $time, got.kind, got.sum);
        error_count++;
      end else begin
        exp_frame = pending_frames.pop_front();
        if (got.kind != exp_frame.kind) begin
          $display("%0t: frame_kind expected %0d actual %0d", $time, exp_frame.kind,
                   got.kind);
          error_count++;
        end
        if (got.axis_x != exp_frame.axis_x) begin
          $display("%0t: axis_x expected %0d actual %0d", $time, exp_frame.axis_x,
                   got.axis_x);
          error_count++;
        end
        if (got.axis_y != exp_frame.axis_y) begin
          $display("%0t: axis_y expected %0d actual %0d", $time, exp_frame.axis_y,
                   got.axis_y);
          error_count++;
        end
        if (got.axis_z != exp_frame.axis_z) begin
          $display("%0t: axis_z expected %0d actual %0d", $time, exp_frame.axis_z,
                   got.axis_z);
          error_count++;
        end
        if (got.temp_q8 != exp_frame.temp_q8) begin
          $display("%0t: temperature_q8 expected %0d actual %0d", $time,
                   exp_frame.temp_q8, got.temp_q8);
          error_count++;
        end
        if (got.sum != exp_frame.sum) begin
          $display("%0t: received_sum expected %h actual %h", $time, exp_frame.sum,
                   got.sum);
          error_count++;
        end
        if (exp_frame.kind <= imusfd_pkg::KIND_ANGLE) kind_seen[exp_frame.kind]++;
        frames_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d frames still due", $time, CYCLE_LIMIT,
               pending_frames.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_kinds();
    test_sync_recovery();
    test_drain_pause();
    test_random_stream();

    // Let the last frames drain through both pipeline stages.
    wait_frames_out();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d frames (accel %0d, gyro %0d, angle %0d).",
             bytes_sent, frames_checked, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("Stream mixed noise, bad type bytes and stalls on both sides; %0d errors.",
             error_count);
    if (error_count == 0 && pending_frames.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
